@@ rtl/core/assert_macros.svh @@
// Assertion macros shared by the RTL core.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked on every rising clock edge outside reset.
`define ASSERT_CLK(lbl, clk, rstn, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) else $error(msg);

// Expression that must never be true outside reset.
`define ASSERT_NEVER(lbl, clk, rstn, expr, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) !(expr)) else $error(msg);

`endif

@@ rtl/core/sbq_pkg.sv @@
// Shared types, constants and helpers for the stereo biquad filter.
`timescale 1ns / 1ps
`default_nettype none

package sbq_pkg;

    // Delay values and y are 32-bit, same LSB as a sample.
    localparam int STATE_W   = 32;
    // Accumulator: delay plus two rounded products of 34 bits each.
    localparam int ACC_W     = 36;
    localparam int CFG_IDX_W = 3;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_NUM_CH = 3'd0,
        REG_B0     = 3'd1,
        REG_B1     = 3'd2,
        REG_B2     = 3'd3,
        REG_A1     = 3'd4,
        REG_A2     = 3'd5
    } cfg_reg_t;

    typedef enum logic [2:0] {
        COEF_B0,
        COEF_B1,
        COEF_B2,
        COEF_A1,
        COEF_A2
    } coef_sel_t;

    typedef enum logic {
        SRC_X,
        SRC_Y
    } src_sel_t;

    typedef enum logic [2:0] {
        ACC_NONE,
        ACC_Y_S1,    // y  = sat(s1 + p)
        ACC_N1_S2,   // n1 = s2 + p
        ACC_N2_ZERO, // n2 = p
        ACC_S1_N1,   // s1 = sat(n1 - p)
        ACC_S2_N2    // s2 = sat(n2 - p)
    } acc_op_t;

    typedef struct packed {
        coef_sel_t coef_sel;
        src_sel_t  src_sel;
        acc_op_t   acc_op;
        logic      ch;
        logic      capture;
        logic      load_x;
        logic      out_load;
    } dp_cmd_t;

    function automatic logic signed [STATE_W-1:0] sat_state(
        input logic signed [ACC_W-1:0] v
    );
        logic [ACC_W-STATE_W:0] top;
        logic signed [STATE_W-1:0] r;
        top = v[ACC_W-1:STATE_W-1];
        if ((&top) || (~|top)) begin
            r = v[STATE_W-1:0];
        end else if (v[ACC_W-1]) begin
            r = {1'b1, {(STATE_W-1){1'b0}}};
        end else begin
            r = {1'b0, {(STATE_W-1){1'b1}}};
        end
        return r;
    endfunction

endpackage

`default_nettype wire

@@ rtl/core/stereo_biquad_filter_top.sv @@
// Top level of the stereo biquad filter: configuration registers and block wiring.
`timescale 1ns / 1ps
`default_nettype none

// Stereo biquad filter, one second-order IIR section in transposed direct
// form II with coefficients shared by both channels. Per active channel:
// y = s1 + b0*x, s1 = s2 - a1*y + b1*x, s2 = -a2*y + b2*x. Samples are
// signed Q1.(SAMPLE_BITS-1), coefficients Q2.(COEF_BITS-2); each product is
// rounded to the sample LSB (half up, then floor), delays and the fed-back y
// are saturated to 32 bits, and the outputs to SAMPLE_BITS. Register 0
// selects the channel count (0 or 1: left only, 2 or 3: both); with one
// channel the right result is zero and the right delays hold. Registers 1..5
// are b0, b1, b2, a1, a2; writes to other indexes are dropped, and the
// configuration channel is always ready. Write configuration only while no
// item is in flight. One shared multiplier with a registered product does
// five products per channel, one channel after the other, and an item
// occupies the block from the accept cycle through the hand-off into the
// output register. The output register lets a new item be accepted while
// the previous result waits for m_ready.
module stereo_biquad_filter_top #(
    parameter int CHANNELS    = 2,
    parameter int SAMPLE_BITS = 24,
    parameter int COEF_BITS   = 16
) (
    input  wire logic                               aclk,
    input  wire logic                               aresetn,
    // input samples
    input  wire logic                               s_valid,
    output logic                                    s_ready,
    input  wire logic signed [SAMPLE_BITS-1:0]      s_sample_left,
    input  wire logic signed [SAMPLE_BITS-1:0]      s_sample_right,
    // filtered results
    output logic                                    m_valid,
    input  wire logic                               m_ready,
    output logic signed [SAMPLE_BITS-1:0]           m_filtered_left,
    output logic signed [SAMPLE_BITS-1:0]           m_filtered_right,
    // configuration writes
    input  wire logic                               cfg_valid,
    output logic                                    cfg_ready,
    input  wire logic [sbq_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  wire logic [COEF_BITS-1:0]               cfg_data
);
    import sbq_pkg::*;

    // Unity gain for b0 at reset.
    localparam logic signed [COEF_BITS-1:0] COEF_ONE = COEF_BITS'(1) <<< (COEF_BITS - 2);

    logic [1:0]                  num_ch_reg;
    logic signed [COEF_BITS-1:0] coef_b0_reg, coef_b1_reg, coef_b2_reg;
    logic signed [COEF_BITS-1:0] coef_a1_reg, coef_a2_reg;
    logic                        two_ch;
    dp_cmd_t                     cmd;

    assign cfg_ready = 1'b1;

    // Register file; a transfer to an unknown index is ignored.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            num_ch_reg  <= 2'd1;
            coef_b0_reg <= COEF_ONE;
            coef_b1_reg <= '0;
            coef_b2_reg <= '0;
            coef_a1_reg <= '0;
            coef_a2_reg <= '0;
        end else if (cfg_valid) begin
            unique case (cfg_index)
                REG_NUM_CH: num_ch_reg  <= cfg_data[1:0];
                REG_B0:     coef_b0_reg <= cfg_data;
                REG_B1:     coef_b1_reg <= cfg_data;
                REG_B2:     coef_b2_reg <= cfg_data;
                REG_A1:     coef_a1_reg <= cfg_data;
                REG_A2:     coef_a2_reg <= cfg_data;
                default:    ;
            endcase
        end
    end

    // Counts 2 and 3 mean stereo; capped by the build.
    assign two_ch = (CHANNELS > 1) && num_ch_reg[1];

    sbq_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .two_ch  (two_ch),
        .cmd     (cmd)
    );

    sbq_datapath #(
        .CHANNELS    (CHANNELS),
        .SAMPLE_BITS (SAMPLE_BITS),
        .COEF_BITS   (COEF_BITS)
    ) u_datapath (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cmd            (cmd),
        .sample_left    (s_sample_left),
        .sample_right   (s_sample_right),
        .coef_b0        (coef_b0_reg),
        .coef_b1        (coef_b1_reg),
        .coef_b2        (coef_b2_reg),
        .coef_a1        (coef_a1_reg),
        .coef_a2        (coef_a2_reg),
        .filtered_left  (m_filtered_left),
        .filtered_right (m_filtered_right)
    );

endmodule

`default_nettype wire

@@ rtl/core/sbq_ctrl.sv @@
// Sequencer for the biquad: steps the shared multiplier through each channel.
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module sbq_ctrl (
    input  wire logic            aclk,
    input  wire logic            aresetn,
    input  wire logic            s_valid,
    output logic                 s_ready,
    output logic                 m_valid,
    input  wire logic            m_ready,
    input  wire logic            two_ch,
    output sbq_pkg::dp_cmd_t     cmd
);
    import sbq_pkg::*;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_RUN,
        ST_OUT
    } state_t;

    localparam logic [2:0] STEP_0    = 3'd0;
    localparam logic [2:0] STEP_1    = 3'd1;
    localparam logic [2:0] STEP_2    = 3'd2;
    localparam logic [2:0] STEP_3    = 3'd3;
    localparam logic [2:0] STEP_4    = 3'd4;
    localparam logic [2:0] STEP_LAST = 3'd5;

    state_t     state_reg;
    logic [2:0] step_reg;
    logic       ch_reg;
    logic       m_valid_reg;

    assign s_ready = (state_reg == ST_IDLE);
    assign m_valid = m_valid_reg;

    always_comb begin
        cmd          = '0;
        cmd.coef_sel = COEF_B0;
        cmd.src_sel  = SRC_X;
        cmd.acc_op   = ACC_NONE;
        cmd.ch       = ch_reg;
        cmd.load_x   = s_valid && (state_reg == ST_IDLE);
        cmd.out_load = (state_reg == ST_OUT) && (!m_valid_reg || m_ready);
        if (state_reg == ST_RUN) begin
            unique case (step_reg)
                STEP_0: begin
                    cmd.coef_sel = COEF_B0;
                end
                STEP_1: begin
                    cmd.coef_sel = COEF_B1;
                    cmd.acc_op   = ACC_Y_S1;
                end
                STEP_2: begin
                    cmd.coef_sel = COEF_B2;
                    cmd.acc_op   = ACC_N1_S2;
                end
                STEP_3: begin
                    cmd.coef_sel = COEF_A1;
                    cmd.src_sel  = SRC_Y;
                    cmd.acc_op   = ACC_N2_ZERO;
                end
                STEP_4: begin
                    cmd.coef_sel = COEF_A2;
                    cmd.src_sel  = SRC_Y;
                    cmd.acc_op   = ACC_S1_N1;
                end
                STEP_LAST: begin
                    cmd.acc_op  = ACC_S2_N2;
                    cmd.capture = 1'b1;
                end
                default: begin
                    cmd.acc_op = ACC_NONE;
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            step_reg    <= STEP_0;
            ch_reg      <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            unique case (state_reg)
                ST_IDLE: begin
                    if (s_valid) begin
                        state_reg <= ST_RUN;
                        step_reg  <= STEP_0;
                        ch_reg    <= 1'b0;
                    end
                end
                ST_RUN: begin
                    if (step_reg == STEP_LAST) begin
                        step_reg <= STEP_0;
                        if (!ch_reg && two_ch) begin
                            ch_reg <= 1'b1;
                        end else begin
                            ch_reg    <= 1'b0;
                            state_reg <= ST_OUT;
                        end
                    end else begin
                        step_reg <= step_reg + 3'd1;
                    end
                end
                ST_OUT: begin
                    if (!m_valid_reg || m_ready) begin
                        state_reg <= ST_IDLE;
                    end
                end
                default: begin
                    state_reg <= ST_IDLE;
                end
            endcase

            if (cmd.out_load) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    `ASSERT_CLK(a_out_load_free, aclk, aresetn,
                cmd.out_load |-> (!m_valid_reg || m_ready), "result overwritten while pending")
    `ASSERT_CLK(a_ready_quiet, aclk, aresetn,
                s_ready |-> (step_reg == STEP_0 && !ch_reg), "ready while an item is in flight")
    `ASSERT_CLK(a_accept_starts, aclk, aresetn,
                (s_valid && s_ready) |=> (state_reg == ST_RUN && step_reg == STEP_0 && !ch_reg),
                "accepted item did not start on channel zero")

endmodule

`default_nettype wire

@@ rtl/core/sbq_datapath.sv @@
// Biquad datapath: shared multiplier, rounding accumulator, delays, result registers.
`timescale 1ns / 1ps
`default_nettype none

module sbq_datapath #(
    parameter int CHANNELS    = 2,
    parameter int SAMPLE_BITS = 24,
    parameter int COEF_BITS   = 16
) (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire sbq_pkg::dp_cmd_t              cmd,
    input  wire logic signed [SAMPLE_BITS-1:0] sample_left,
    input  wire logic signed [SAMPLE_BITS-1:0] sample_right,
    input  wire logic signed [COEF_BITS-1:0]   coef_b0,
    input  wire logic signed [COEF_BITS-1:0]   coef_b1,
    input  wire logic signed [COEF_BITS-1:0]   coef_b2,
    input  wire logic signed [COEF_BITS-1:0]   coef_a1,
    input  wire logic signed [COEF_BITS-1:0]   coef_a2,
    output logic signed [SAMPLE_BITS-1:0]      filtered_left,
    output logic signed [SAMPLE_BITS-1:0]      filtered_right
);
    import sbq_pkg::*;

    localparam int PROD_W = COEF_BITS + STATE_W;
    localparam int FB     = COEF_BITS - 2;
    localparam int DEPTH  = 2 * CHANNELS;
    localparam int SI_W   = $clog2(DEPTH);
    localparam logic signed [PROD_W-1:0] HALF = PROD_W'(64'sd1 <<< (FB - 1));

    logic signed [SAMPLE_BITS-1:0] x_left_reg, x_right_reg;
    logic signed [PROD_W-1:0]      prod_reg, prod_next;
    logic signed [STATE_W-1:0]     y_reg;
    logic signed [ACC_W-1:0]       n1_reg, n2_reg;
    logic signed [STATE_W-1:0]     delay_reg [DEPTH];
    logic signed [SAMPLE_BITS-1:0] hold_left_reg, hold_right_reg;
    logic signed [SAMPLE_BITS-1:0] out_left_reg, out_right_reg;

    logic signed [COEF_BITS-1:0]   mul_coef;
    logic signed [STATE_W-1:0]     mul_opnd;
    logic signed [SAMPLE_BITS-1:0] x_sel;
    logic signed [PROD_W-1:0]      rnd, shifted;
    logic signed [ACC_W-1:0]       term, base, sum;
    logic signed [STATE_W-1:0]     sum_sat;
    logic                          use_s2;
    logic [SI_W-1:0]               rd_idx;
    logic [STATE_W-SAMPLE_BITS:0]  y_top;
    logic signed [SAMPLE_BITS-1:0] y_sat;

    // Channel one only exists when built for two channels.
    assign x_sel = (CHANNELS > 1 && cmd.ch) ? x_right_reg : x_left_reg;

    always_comb begin
        unique case (cmd.coef_sel)
            COEF_B0: mul_coef = coef_b0;
            COEF_B1: mul_coef = coef_b1;
            COEF_B2: mul_coef = coef_b2;
            COEF_A1: mul_coef = coef_a1;
            COEF_A2: mul_coef = coef_a2;
            default: mul_coef = coef_b0;
        endcase
    end

    assign mul_opnd  = (cmd.src_sel == SRC_Y) ? y_reg : STATE_W'(x_sel);
    assign prod_next = PROD_W'(mul_coef) * PROD_W'(mul_opnd);

    // Round to the sample LSB: add half, floor.
    assign rnd     = prod_reg + HALF;
    assign shifted = rnd >>> FB;
    assign term    = signed'(shifted[ACC_W-1:0]);

    assign use_s2 = (cmd.acc_op == ACC_N1_S2) || (cmd.acc_op == ACC_S2_N2);
    assign rd_idx = SI_W'({cmd.ch, use_s2});

    always_comb begin
        case (cmd.acc_op)
            ACC_Y_S1, ACC_N1_S2: base = ACC_W'(delay_reg[rd_idx]);
            ACC_S1_N1:           base = n1_reg;
            ACC_S2_N2:           base = n2_reg;
            default:             base = '0;
        endcase
        if (cmd.acc_op == ACC_S1_N1 || cmd.acc_op == ACC_S2_N2) begin
            sum = base - term;
        end else begin
            sum = base + term;
        end
    end

    assign sum_sat = sat_state(sum);

    // Output saturation to the sample width.
    assign y_top = y_reg[STATE_W-1:SAMPLE_BITS-1];
    always_comb begin
        if ((&y_top) || (~|y_top)) begin
            y_sat = y_reg[SAMPLE_BITS-1:0];
        end else if (y_reg[STATE_W-1]) begin
            y_sat = {1'b1, {(SAMPLE_BITS-1){1'b0}}};
        end else begin
            y_sat = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
        end
    end

    always_ff @(posedge aclk) begin
        prod_reg <= prod_next;
        if (cmd.load_x) begin
            x_left_reg     <= sample_left;
            x_right_reg    <= sample_right;
            hold_left_reg  <= '0;
            hold_right_reg <= '0;
        end
        case (cmd.acc_op)
            ACC_Y_S1:    y_reg  <= sum_sat;
            ACC_N1_S2:   n1_reg <= sum;
            ACC_N2_ZERO: n2_reg <= sum;
            default:     ;
        endcase
        if (cmd.capture) begin
            if (cmd.ch) begin
                hold_right_reg <= y_sat;
            end else begin
                hold_left_reg <= y_sat;
            end
        end
        if (cmd.out_load) begin
            out_left_reg  <= hold_left_reg;
            out_right_reg <= hold_right_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < DEPTH; i++) begin
                delay_reg[i] <= '0;
            end
        end else if (cmd.acc_op == ACC_S1_N1 || cmd.acc_op == ACC_S2_N2) begin
            delay_reg[rd_idx] <= sum_sat;
        end
    end

    assign filtered_left  = out_left_reg;
    assign filtered_right = out_right_reg;

endmodule

`default_nettype wire
